>>> hdl/salc_pkg.sv
`default_nettype none

package salc_pkg;

  // Built geometry defaults.
  localparam int DefMaxSets   = 64;
  localparam int DefNumWays   = 8;
  localparam int DefAddrWidth = 64;

  localparam int StampW   = 32;
  localparam int TotalW   = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;
  localparam int RawSetW  = 7;

  // Access kinds.
  localparam logic [1:0] ReqFetch  = 2'd0;
  localparam logic [1:0] ReqModify = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSetBits   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaysInUse = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic              was_hit;
    logic              was_miss;
    logic              was_evicted;
    logic [TotalW-1:0] hits_total;
    logic [TotalW-1:0] misses_total;
    logic [TotalW-1:0] evictions_total;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic clear_we;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    return (v == '1) ? v : v + TotalW'(1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/salc_ram.sv
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/salc_ctrl.sv
`default_nettype none

module salc_ctrl
  import salc_pkg::*;
#(
  parameter int MAX_SETS = DefMaxSets
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] clear_idx_o
);

  localparam int SetIdxW = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;

  typedef enum logic [2:0] {
    StClear  = 3'b001,
    StIdle   = 3'b010,
    StLookup = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [SetIdxW-1:0] clr_q, clr_d;
  logic clr_last;

  assign clr_last = (clr_q == SetIdxW'(MAX_SETS - 1));

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_we = 1'b1;
        clr_d = clr_q + SetIdxW'(1);
        if (clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign clear_idx_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == StLookup))
    else $error("accepted transaction did not enter lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_we |-> !cmd_o.accept && !cmd_o.commit)
    else $error("clearing pass overlaps a transaction");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == StIdle))
    else $error("commit did not return to idle");
`endif

endmodule

`default_nettype wire

>>> hdl/salc_dp.sv
`default_nettype none

module salc_dp
  import salc_pkg::*;
#(
  parameter int MAX_SETS   = DefMaxSets,
  parameter int NUM_WAYS   = DefNumWays,
  parameter int ADDR_WIDTH = DefAddrWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire req_t                  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output res_t                       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_wdata_i,
  input  wire cmd_t                  cmd_i,
  input  wire logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] clear_idx_i,
  output sts_t                       sts_o
);

  localparam int SetIdxW = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int WayW    = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
  localparam int CntW    = $clog2(NUM_WAYS + 1) > 4 ? $clog2(NUM_WAYS + 1) : 4;
  localparam int EntW    = 1 + ADDR_WIDTH + StampW;
  localparam int RowW    = NUM_WAYS * EntW;
  localparam int RawSets = 1 << RawSetW;

  // Configuration registers.
  logic [2:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSetBits:   set_bits_q   <= cfg_wdata_i[2:0];
        CfgBlockBits: block_bits_q <= cfg_wdata_i[5:0];
        CfgWaysInUse: ways_q       <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Set index folding table for a raw index of up to seven bits.
  logic [SetIdxW-1:0] set_mod_tbl [RawSets];
  for (genvar i = 0; i < RawSets; i++) begin : g_mod
    assign set_mod_tbl[i] = SetIdxW'(i % MAX_SETS);
  end

  // Address split on the incoming transaction.
  logic [ADDR_WIDTH-1:0] addr_w, addr_sh;
  logic [6:0]            tshift;
  logic [RawSetW-1:0]    set_mask, set_raw;
  logic [SetIdxW-1:0]    set_idx;
  logic [ADDR_WIDTH-1:0] tag_in;

  assign addr_w   = in_data_i.address[ADDR_WIDTH-1:0];
  assign addr_sh  = addr_w >> block_bits_q;
  assign set_mask = (RawSetW'(1) << set_bits_q) - RawSetW'(1);
  assign set_raw  = addr_sh[RawSetW-1:0] & set_mask;
  assign set_idx  = set_mod_tbl[set_raw];
  assign tshift   = 7'(set_bits_q) + 7'(block_bits_q);
  assign tag_in   = (tshift >= 7'(ADDR_WIDTH)) ? '0 : (addr_w >> tshift);

  logic [1:0]            type_q;
  logic [SetIdxW-1:0]    idx_q;
  logic [ADDR_WIDTH-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q <= in_data_i.req_type;
      idx_q  <= set_idx;
      tag_q  <= tag_in;
    end
  end

  // Line memory: one row per set holding every way.
  logic              ram_we;
  logic [SetIdxW-1:0] ram_waddr;
  logic [RowW-1:0]   ram_wdata, row, new_row;
  logic              upd_we;

  assign ram_we    = cmd_i.clear_we || upd_we;
  assign ram_waddr = cmd_i.clear_we ? clear_idx_i : idx_q;
  assign ram_wdata = cmd_i.clear_we ? '0 : new_row;

  salc_ram #(
    .WIDTH (RowW),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (set_idx),
    .rdata_o (row)
  );

  // Lookup over the ways of the row.
  logic [StampW-1:0]     clock_q, clk_new;
  logic [CntW-1:0]       ways_ext, wu;
  logic [NUM_WAYS-1:0]   in_use, vld, match, cand;
  logic [ADDR_WIDTH-1:0] tags  [NUM_WAYS];
  logic [StampW-1:0]     stamp [NUM_WAYS];

  assign clk_new  = clock_q + StampW'(1);
  assign ways_ext = CntW'(ways_q);
  assign wu = (ways_ext == '0) ? CntW'(1) :
              (ways_ext > CntW'(NUM_WAYS)) ? CntW'(NUM_WAYS) : ways_ext;

  for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
    assign stamp[w]  = row[w*EntW +: StampW];
    assign tags[w]   = row[w*EntW + StampW +: ADDR_WIDTH];
    assign vld[w]    = row[w*EntW + EntW - 1];
    assign in_use[w] = (CntW'(w) < wu);
    assign match[w]  = in_use[w] && vld[w] && (tags[w] == tag_q);
  end

  // A way is the victim candidate when its stamp is the first minimum below the
  // current clock among the ways in use.
  always_comb begin
    cand = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      cand[w] = in_use[w] && (stamp[w] < clk_new);
      for (int j = 0; j < NUM_WAYS; j++) begin
        if (in_use[j] && j < w && !(stamp[w] < stamp[j])) begin
          cand[w] = 1'b0;
        end
        if (in_use[j] && j > w && !(stamp[w] <= stamp[j])) begin
          cand[w] = 1'b0;
        end
      end
    end
  end

  logic [WayW-1:0] hit_way, empty_way, victim, slot;
  logic            hit, any_empty, is_fetch;

  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    victim    = '0;
    any_empty = 1'b0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WayW'(w);
      end
      if (cand[w]) begin
        victim = WayW'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (in_use[w] && !vld[w]) begin
        empty_way = WayW'(w);
        any_empty = 1'b1;
      end
    end
  end

  assign hit      = |match;
  assign is_fetch = (type_q == ReqFetch);
  assign slot     = hit ? hit_way : (any_empty ? empty_way : victim);
  assign upd_we   = cmd_i.commit && !is_fetch;

  always_comb begin
    new_row = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WayW'(w) == slot) begin
        new_row[w*EntW +: EntW] = {1'b1, tag_q, clk_new};
      end
    end
  end

  // Totals and result.
  logic [TotalW-1:0] hits_q, misses_q, evicts_q;
  logic [TotalW-1:0] hits_d, hits_one, misses_d, evicts_d;
  logic              r_hit, r_miss, r_evict;

  assign r_hit   = !is_fetch && hit;
  assign r_miss  = !is_fetch && !hit;
  assign r_evict = r_miss && !any_empty;

  assign hits_one = r_hit ? sat_inc(hits_q) : hits_q;
  assign hits_d   = (type_q == ReqModify) ? sat_inc(hits_one) : hits_one;
  assign misses_d = r_miss ? sat_inc(misses_q) : misses_q;
  assign evicts_d = r_evict ? sat_inc(evicts_q) : evicts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      if (!is_fetch) begin
        clock_q <= clk_new;
      end
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  logic out_valid_q;
  res_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= '{was_hit: r_hit, was_miss: r_miss, was_evicted: r_evict,
                      hits_total: hits_d, misses_total: misses_d,
                      evictions_total: evicts_d};
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.was_hit && out_data_q.was_miss))
    else $error("result is both hit and miss");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.was_evicted) |-> out_data_q.was_miss)
    else $error("eviction without miss");
`endif

endmodule

`default_nettype wire

>>> hdl/set_assoc_lru_cache_tracker.sv
`default_nettype none

// Set-associative cache tracker with least-recently-used replacement. Each
// transaction on the input channel is one memory access (kind and byte
// address); each produces exactly one result transaction carrying this
// access's hit, miss and eviction flags and saturating running totals. In
// the cycle an access is accepted the set's row is read from the line memory,
// and in the next cycle all ways are compared and the victim is chosen; the
// updated row is written back, unless the access is a fetch, once the output
// register can take the result. The next access can be accepted in the cycle
// after that, so no new access is taken before the previous one is done;
// while the receiver holds back the result in the output register, the
// write-back of the following access waits until that result is taken, and
// the input stays stalled meanwhile. After reset a clearing pass empties the
// line memory, during which no input transaction is accepted; configuration
// writes are taken at any time. Instruction fetches still produce a result
// with unchanged totals. The age stamps are 32-bit and wrap, so replacement
// order is exact only for fewer than 2^32 non-fetch accesses after reset.
module set_assoc_lru_cache_tracker
  import salc_pkg::*;
#(
  parameter int MAX_SETS   = DefMaxSets,
  parameter int NUM_WAYS   = DefNumWays,
  parameter int ADDR_WIDTH = DefAddrWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire req_t                in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output res_t                     out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int SetIdxW = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;

  cmd_t               cmd;
  sts_t               sts;
  logic [SetIdxW-1:0] clear_idx;

  // The controller sequences the clearing pass and each transaction.
  salc_ctrl #(
    .MAX_SETS (MAX_SETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .clear_idx_o (clear_idx)
  );

  // The datapath holds the configuration, the line memory, the totals and the
  // output register.
  salc_dp #(
    .MAX_SETS   (MAX_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .clear_idx_i (clear_idx),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> verif/set_assoc_lru_cache_tracker_test.sv
`default_nettype none

module set_assoc_lru_cache_tracker_test;
  import salc_pkg::*;

  // Access kinds that the package does not name.
  localparam logic [1:0] ReqLoad  = 2'd1;
  localparam logic [1:0] ReqStore = 2'd2;
  // Register index that the block does not decode; a write to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam int Sets = 64;
  localparam int Ways = 8;
  localparam int PoolSize = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  always #5 clk_i = ~clk_i;

  set_assoc_lru_cache_tracker DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Our own copy of the cache: line array, age stamps, totals and registers.
  bit          line_ok [Sets][Ways];
  logic [63:0] line_tag [Sets][Ways];
  logic [31:0] line_age [Sets][Ways];
  logic [31:0] age_clock, hits_exp, misses_exp, evicts_exp;
  logic [2:0]  set_bits_r;
  logic [5:0]  block_bits_r;
  logic [3:0]  ways_r;

  res_t        pending_results[$];
  logic [63:0] addr_pool[PoolSize];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Works out the result of one access and updates the mirrored cache,
  // scanning the ways in the same order as the hardware so that the choice
  // of empty slot and victim agrees exactly.
  function automatic res_t predict_access(input req_t r);
    res_t        e;
    logic [63:0] tg, mask;
    logic [31:0] oldest;
    int          set, ways, tshift, victim, empty, w, slot;
    bit          found;
    e = '0;
    if (r.req_type != ReqFetch) begin
      ways = (ways_r == 0) ? 1 : ((ways_r > Ways) ? Ways : ways_r);
      tshift = set_bits_r + block_bits_r;
      mask = (64'd1 << set_bits_r) - 64'd1;
      set = int'(((r.address >> block_bits_r) & mask) % Sets);
      tg = (tshift >= 64) ? 64'd0 : (r.address >> tshift);
      age_clock = age_clock + 32'd1;
      oldest = age_clock;
      victim = 0;
      empty = -1;
      found = 0;
      for (w = 0; w < ways && !found; w++) begin
        if (line_ok[set][w]) begin
          if (line_tag[set][w] == tg) begin
            found = 1;
            line_age[set][w] = age_clock;
          end else if (line_age[set][w] < oldest) begin
            oldest = line_age[set][w];
            victim = w;
          end
        end else begin
          empty = w;
        end
      end
      if (found) begin
        e.was_hit = 1'b1;
        hits_exp = bump(hits_exp);
      end else begin
        e.was_miss = 1'b1;
        misses_exp = bump(misses_exp);
        if (empty >= 0) begin
          slot = empty;
        end else begin
          slot = victim;
          e.was_evicted = 1'b1;
          evicts_exp = bump(evicts_exp);
        end
        line_ok[set][slot] = 1'b1;
        line_tag[set][slot] = tg;
        line_age[set][slot] = age_clock;
      end
      if (r.req_type == ReqModify) hits_exp = bump(hits_exp);
    end
    e.hits_total = hits_exp;
    e.misses_total = misses_exp;
    e.evictions_total = evicts_exp;
    return e;
  endfunction

  // Offers one access. It is entered at a falling edge and leaves at one with
  // valid still high, so a following access is presented without a gap.
  task automatic send_access(input logic [1:0] kind, input logic [63:0] addr);
    req_t r;
    int   gap;
    r.req_type = kind;
    r.address = addr;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_access(r));
    sent++;
    @(negedge clk_i);
  endtask

  // Waits for every outstanding result, then lets the clock run on so that the
  // block is idle before the registers are touched.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSetBits:   set_bits_r = val[2:0];
      CfgBlockBits: block_bits_r = val;
      CfgWaysInUse: ways_r = val[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int sb, input int bb, input int wy);
    write_reg(CfgSetBits, CfgDataW'(sb));
    write_reg(CfgBlockBits, CfgDataW'(bb));
    write_reg(CfgWaysInUse, CfgDataW'(wy));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Fills the address pool for the current geometry. The set field is forced
  // to a handful of values so that sets fill up and evictions happen.
  task automatic refill_pool;
    logic [63:0] smask;
    smask = ((64'd1 << set_bits_r) - 64'd1) << block_bits_r;
    foreach (addr_pool[i])
      addr_pool[i] = (rand64() & ~smask) |
                     ((64'($urandom_range(0, 3)) << block_bits_r) & smask);
  endtask

  // Mostly reuses pool addresses with random offset bits so that hits,
  // misses and evictions all occur; the rest are fully random addresses.
  task automatic random_accesses(input int count);
    logic [63:0] addr, omask;
    omask = (64'd1 << block_bits_r) - 64'd1;
    repeat (count) begin
      if ($urandom_range(0, 99) < 80)
        addr = addr_pool[$urandom_range(0, PoolSize - 1)] ^ (rand64() & omask);
      else
        addr = rand64();
      send_access(2'($urandom_range(0, 3)), addr);
    end
  endtask

  task automatic test_directed;
    int w;
    // Default geometry: one set, one way.
    send_access(ReqFetch, 64'h0);
    send_access(ReqLoad, 64'h0);
    send_access(ReqLoad, 64'h0);
    send_access(ReqFetch, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ReqStore, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ReqModify, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ReqModify, 64'h1);
    drain();
    // All eight ways of one set, then one more tag to force an LRU eviction,
    // then a touch of the oldest survivor.
    configure(6, 4, Ways);
    for (w = 0; w < 9; w++) send_access(ReqLoad, 64'(w) << 10);
    send_access(ReqLoad, 64'h400);
    send_access(ReqStore, 64'h0);
    send_access(ReqModify, 64'h800);
    // Highest set index, with the very top address bit set in the tag.
    send_access(ReqLoad, 64'h8000_0000_0000_03F0);
    drain();
  endtask

  // Receiver holds off for a long stretch while accesses keep coming, so the
  // block fills and stalls its input.
  task automatic test_backpressure;
    configure(3, 5, 4);
    refill_pool();
    hold_cycles = 200;
    random_accesses(30);
    drain();
  endtask

  // Walks through a range of geometries, the extremes and the special
  // register values among them.
  task automatic test_random_geometries;
    int geo [8][3] = '{'{0, 0, 1}, '{6, 4, 8}, '{7, 2, 4}, '{3, 63, 2},
                       '{2, 58, 0}, '{6, 60, 15}, '{1, 5, 8}, '{4, 3, 3}};
    int g;
    for (g = 0; g < 8; g++) begin
      // Idling pattern: sender light and receiver heavy, then the reverse,
      // then both flat out.
      if (g < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 48;
      end else if (g < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(geo[g][0], geo[g][1], geo[g][2]);
      if (g == 4) write_reg(CfgUnused, 6'h3F);
      refill_pool();
      random_accesses(100);
      drain();
    end
  endtask

  // Receiver stall, changed at the falling edge only.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $realtime, out_data_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        report_field("was_hit", e.was_hit, out_data_o.was_hit);
        report_field("was_miss", e.was_miss, out_data_o.was_miss);
        report_field("was_evicted", e.was_evicted, out_data_o.was_evicted);
        report_field("hits_total", e.hits_total, out_data_o.hits_total);
        report_field("misses_total", e.misses_total, out_data_o.misses_total);
        report_field("evictions_total", e.evictions_total, out_data_o.evictions_total);
        checked++;
      end
    end
  end

  initial begin
    int waited;
    foreach (line_ok[s, w]) begin
      line_ok[s][w] = 1'b0;
      line_tag[s][w] = '0;
      line_age[s][w] = '0;
    end
    age_clock = '0;
    hits_exp = '0;
    misses_exp = '0;
    evicts_exp = '0;
    set_bits_r = '0;
    block_bits_r = '0;
    ways_r = 4'd1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_random_geometries();

    waited = 0;
    while (pending_results.size() != 0 && waited < 10000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, pending_results.size());
      errors += pending_results.size();
    end
    $display("Sent %0d accesses over nine geometries, including backpressure and idling.",
             sent);
    $display("Checked %0d results; %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety net: no correct run comes near this.
  initial begin
    #20000000;
    $display("Run timed out.");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
